/* rtl/ifd_pkg.sv */
// Shared types, constants and the arctangent table of the fall detector.
package ifd_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CordicIters  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int SqrtIters    = 16;
  localparam int MaxIters     = (CordicIters > SqrtIters) ? CordicIters : SqrtIters;
  localparam int IterW        = $clog2(MaxIters);

  // CORDIC vector and angle accumulator widths
  localparam int CordicW = 28;
  localparam int AngleW  = 25;
  localparam int AtanW   = 22;

  localparam logic signed [15:0] AngleMax = 16'sd23040;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgImpact = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTilt   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHold   = 2'd2;

  localparam logic [15:0] ImpactReset = 16'd10240;
  localparam logic [14:0] TiltReset   = 15'd15360;
  localparam logic [15:0] HoldReset   = 16'd10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_CINIT,
    ST_CORDIC,
    ST_ANGLE,
    ST_DONE
  } ifd_state_e;

  typedef struct packed {
    logic             load;
    logic             square;
    logic             sum;
    logic             sqrt_step;
    logic             cordic_init;
    logic             cordic_step;
    logic             angle;
    logic             finish;
    logic [IterW-1:0] iter;
  } ifd_cmd_t;

  typedef struct packed {
    logic clear_req;
  } ifd_sts_t;

  // atan(2^-i) in degrees * 65536, rounded
  function automatic logic [AtanW-1:0] atan_entry(input logic [4:0] idx);
    logic [AtanW-1:0] val;
    case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/ifd_intf.sv */
// Valid/ready channel interfaces for samples and results.
interface ifd_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [31:0]        now_ms;

  modport source (output valid, req_type, accel_x, accel_y, accel_z, now_ms, input ready);
  modport sink (input valid, req_type, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

interface ifd_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        total_accel;
  logic signed [15:0] pitch_deg;
  logic signed [15:0] roll_deg;
  logic               is_fall;

  modport source (output valid, total_accel, pitch_deg, roll_deg, is_fall, input ready);
  modport sink (input valid, total_accel, pitch_deg, roll_deg, is_fall, output ready);
endinterface

/* rtl/imu_fall_detector_unit.sv */
// Top level of the accelerometer fall detector.
// Each sample steps through load, square, sum, the bit-serial square roots (16
//   steps), CORDIC init, the CORDIC rotations (one per cycle, capped at 24) and
//   angle, then waits in done for a free result slot; a clear request goes
//   from square straight to done. A new sample is taken only once idle again.
// Reset (rst_ni low, asynchronous): thresholds return to their defaults, the fall
//   latch and its time clear, and no result is pending.
module imu_fall_detector_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ifd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                 cfg_wdata_i,
  ifd_in_if.sink                      sample_i,
  ifd_out_if.source                   result_o
);
  import ifd_pkg::*;

  // Command and status between the sequencer and the datapath.
  ifd_cmd_t cmd;
  ifd_sts_t sts;

  // The sequencer owns both handshakes. A sample transfers only while the
  // sequencer is idle, but it does so even if the previous result still
  // waits on the output: the result register holds that result, and the new
  // item is stalled only at its last step until the slot is free.
  ifd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath captures the request, squares the axes, runs three square
  // roots side by side (magnitude and both angle denominators), then two
  // CORDIC lanes for pitch and roll, and finally decides the fall latch.
  // A latch and an expiry check in one step see a zero elapsed time, so a
  // fresh fall always survives its own sample.
  ifd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (sample_i.req_type),
    .accel_x_i     (sample_i.accel_x),
    .accel_y_i     (sample_i.accel_y),
    .accel_z_i     (sample_i.accel_z),
    .now_ms_i      (sample_i.now_ms),
    .total_accel_o (result_o.total_accel),
    .pitch_deg_o   (result_o.pitch_deg),
    .roll_deg_o    (result_o.roll_deg),
    .is_fall_o     (result_o.is_fall)
  );

endmodule

/* rtl/ifd_sqrt_unit.sv */
// Bit-serial rounded integer square root, one result bit per step.
module ifd_sqrt_unit (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        step_i,
  input  logic [31:0] rad_i,
  output logic [15:0] root_o
);
  import ifd_pkg::*;

  logic [31:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [31:0] bit_q, bit_d;
  logic [31:0] trial;

  always_comb begin
    trial  = root_q + bit_q;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (load_i) begin
      rem_d  = rad_i;
      root_d = '0;
      bit_d  = 32'h4000_0000;
    end else if (step_i) begin
      if (rem_q >= trial) begin
        rem_d  = rem_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  // round to nearest: remainder above the floor root
  assign root_o = root_q[15:0] + {15'd0, (rem_q > root_q)};

endmodule

/* rtl/ifd_cordic_unit.sv */
// Vectoring CORDIC, one rotation per step, angle out in degrees Q8.8.
module ifd_cordic_unit (
  input  logic                     clk_i,
  input  logic                     init_i,
  input  logic                     step_i,
  input  logic [ifd_pkg::IterW-1:0] iter_i,
  input  logic signed [15:0]       num_i,
  input  logic [15:0]              den_i,
  output logic signed [15:0]       angle_o
);
  import ifd_pkg::*;

  logic signed [CordicW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [AngleW-1:0]  z_q, z_d, step_ang, z_rnd;
  logic                      zero_q, zero_d;

  always_comb begin
    xs       = x_q >>> iter_i;
    ys       = y_q >>> iter_i;
    step_ang = signed'({{(AngleW-AtanW){1'b0}}, atan_entry(5'(iter_i))});
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    zero_d   = zero_q;
    if (init_i) begin
      x_d    = signed'({{(CordicW-24){1'b0}}, den_i, 8'h00});
      y_d    = signed'({{(CordicW-24){num_i[15]}}, num_i, 8'h00});
      z_d    = '0;
      zero_d = (num_i == 16'sd0) && (den_i == 16'd0);
    end else if (step_i) begin
      if (!y_q[CordicW-1]) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + step_ang;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - step_ang;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  // round to Q8.8 and clamp
  always_comb begin
    z_rnd = (z_q + AngleW'(128)) >>> 8;
    if (zero_q) begin
      angle_o = '0;
    end else if (z_rnd > AngleW'(AngleMax)) begin
      angle_o = AngleMax;
    end else if (z_rnd < -AngleW'(AngleMax)) begin
      angle_o = -AngleMax;
    end else begin
      angle_o = z_rnd[15:0];
    end
  end

endmodule

/* rtl/ifd_ctrl.sv */
// Sequencer of the fall detector: steps the datapath through one request.
module ifd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ifd_pkg::ifd_sts_t sts_i,
  output ifd_pkg::ifd_cmd_t cmd_o
);
  import ifd_pkg::*;

  localparam logic [IterW-1:0] SqrtLast   = IterW'(SqrtIters - 1);
  localparam logic [IterW-1:0] CordicLast = IterW'(CordicIters - 1);

  ifd_state_e       state_q, state_d;
  logic [IterW-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.iter = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = sts_i.clear_req ? ST_DONE : ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        cnt_d     = '0;
        state_d   = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == SqrtLast) begin
          cnt_d   = '0;
          state_d = ST_CINIT;
        end
      end
      ST_CINIT: begin
        cmd_o.cordic_init = 1'b1;
        cnt_d             = '0;
        state_d           = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        cnt_d             = cnt_q + 1'b1;
        if (cnt_q == CordicLast) begin
          cnt_d   = '0;
          state_d = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result slot is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result written over an untaken result");

  a_sqrt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (cnt_q <= SqrtLast))
    else $error("square root iteration count overran");

  a_cordic_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORDIC && cnt_q == CordicLast) |=> (state_q == ST_ANGLE))
    else $error("CORDIC did not end after its last rotation");

endmodule

/* rtl/ifd_datapath.sv */
// Datapath: squares, three square roots, two CORDIC lanes, fall latch, result.
module ifd_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ifd_pkg::ifd_cmd_t          cmd_i,
  output ifd_pkg::ifd_sts_t          sts_o,
  input  logic                       cfg_we_i,
  input  logic [ifd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                cfg_wdata_i,
  input  logic                       req_type_i,
  input  logic signed [15:0]         accel_x_i,
  input  logic signed [15:0]         accel_y_i,
  input  logic signed [15:0]         accel_z_i,
  input  logic [31:0]                now_ms_i,
  output logic [15:0]                total_accel_o,
  output logic signed [15:0]         pitch_deg_o,
  output logic signed [15:0]         roll_deg_o,
  output logic                       is_fall_o
);
  import ifd_pkg::*;

  // configuration
  logic [15:0] impact_q;
  logic [14:0] tilt_th_q;
  logic [15:0] hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      impact_q  <= ImpactReset;
      tilt_th_q <= TiltReset;
      hold_q    <= HoldReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgImpact: impact_q  <= cfg_wdata_i;
        CfgTilt:   tilt_th_q <= cfg_wdata_i[14:0];
        CfgHold:   hold_q    <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // captured request
  logic               req_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic [31:0]        now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      ax_q  <= accel_x_i;
      ay_q  <= accel_y_i;
      az_q  <= accel_z_i;
      now_q <= now_ms_i;
    end
  end

  assign sts_o.clear_req = req_q;

  // squares
  logic signed [31:0] prod_x, prod_y, prod_z;
  logic [31:0]        sqx_q, sqy_q, sqz_q;

  assign prod_x = ax_q * ax_q;
  assign prod_y = ay_q * ay_q;
  assign prod_z = az_q * az_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sqx_q <= unsigned'(prod_x);
      sqy_q <= unsigned'(prod_y);
      sqz_q <= unsigned'(prod_z);
    end
  end

  // square roots: magnitude, pitch denominator, roll denominator
  logic [31:0] rad_mag, rad_pitch, rad_roll;
  logic [15:0] root_mag, root_pitch, root_roll;

  assign rad_mag   = sqx_q + sqy_q + sqz_q;
  assign rad_pitch = sqy_q + sqz_q;
  assign rad_roll  = sqx_q + sqz_q;

  ifd_sqrt_unit u_sqrt_mag (
    .clk_i  (clk_i),
    .load_i (cmd_i.sum),
    .step_i (cmd_i.sqrt_step),
    .rad_i  (rad_mag),
    .root_o (root_mag)
  );

  ifd_sqrt_unit u_sqrt_pitch (
    .clk_i  (clk_i),
    .load_i (cmd_i.sum),
    .step_i (cmd_i.sqrt_step),
    .rad_i  (rad_pitch),
    .root_o (root_pitch)
  );

  ifd_sqrt_unit u_sqrt_roll (
    .clk_i  (clk_i),
    .load_i (cmd_i.sum),
    .step_i (cmd_i.sqrt_step),
    .rad_i  (rad_roll),
    .root_o (root_roll)
  );

  // angles
  logic signed [15:0] ang_pitch, ang_roll;
  logic signed [15:0] pitch_q, roll_q;

  ifd_cordic_unit u_cordic_pitch (
    .clk_i   (clk_i),
    .init_i  (cmd_i.cordic_init),
    .step_i  (cmd_i.cordic_step),
    .iter_i  (cmd_i.iter),
    .num_i   (ax_q),
    .den_i   (root_pitch),
    .angle_o (ang_pitch)
  );

  ifd_cordic_unit u_cordic_roll (
    .clk_i   (clk_i),
    .init_i  (cmd_i.cordic_init),
    .step_i  (cmd_i.cordic_step),
    .iter_i  (cmd_i.iter),
    .num_i   (ay_q),
    .den_i   (root_roll),
    .angle_o (ang_roll)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.angle) begin
      pitch_q <= ang_pitch;
      roll_q  <= ang_roll;
    end
  end

  // fall decision
  logic        fall_latched_q, fall_latched_d;
  logic [31:0] fall_time_q, fall_time_d;
  logic [15:0] abs_pitch, abs_roll;
  logic [14:0] tilt;
  logic        trigger, latched_now;
  logic [31:0] elapsed;

  always_comb begin
    abs_pitch      = pitch_q[15] ? 16'(-pitch_q) : pitch_q;
    abs_roll       = roll_q[15] ? 16'(-roll_q) : roll_q;
    tilt           = (abs_pitch > abs_roll) ? abs_pitch[14:0] : abs_roll[14:0];
    trigger        = (root_mag > impact_q) && (tilt > tilt_th_q);
    latched_now    = fall_latched_q || trigger;
    fall_time_d    = trigger ? now_q : fall_time_q;
    elapsed        = now_q - fall_time_d;
    fall_latched_d = latched_now && !(elapsed > {16'd0, hold_q});
    if (req_q) begin
      fall_latched_d = 1'b0;
      fall_time_d    = fall_time_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_latched_q <= 1'b0;
      fall_time_q    <= '0;
    end else if (cmd_i.finish) begin
      fall_latched_q <= fall_latched_d;
      fall_time_q    <= fall_time_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      total_accel_o <= req_q ? 16'd0 : root_mag;
      pitch_deg_o   <= req_q ? 16'sd0 : pitch_q;
      roll_deg_o    <= req_q ? 16'sd0 : roll_q;
      is_fall_o     <= fall_latched_d;
    end
  end

  a_clear_drops_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && req_q) |=> !fall_latched_q)
    else $error("clear request left the fall latched");

  a_result_matches_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (is_fall_o == fall_latched_q))
    else $error("reported fall flag differs from latch");

endmodule

/* tb/sv/imu_fall_detector_unit_tb.sv */
// Self-checking testbench of the accelerometer fall detector unit.
`timescale 1ns / 100ps

module imu_fall_detector_unit_tb;
  import ifd_pkg::*;

  // Request codes carried in req_type
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Slowest correct run: about 1550 transfers, each with the block's full
  // processing plus the longest sender gap and receiver stall. Take that
  // several times over.
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        now_ms;
  } imu_req_t;

  typedef struct packed {
    logic [15:0]        total_accel;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] roll_deg;
    logic               is_fall;
  } imu_reading_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [15:0]         cfg_wdata_i;

  ifd_in_if  smp_if ();
  ifd_out_if res_if ();

  imu_fall_detector_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (smp_if),
    .result_o    (res_if)
  );

  always #4 clk_i = ~clk_i;

  // atan(2^-i) in degrees scaled by 65536, rounded to nearest
  longint atan_deg16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Shadow copy of the detector: thresholds, latch and latch time
  logic [15:0] thr_impact = ImpactReset;
  logic [14:0] thr_tilt   = TiltReset;
  logic [15:0] hold_ms    = HoldReset;
  logic        fall_flag  = 1'b0;
  logic [31:0] fall_stamp = '0;

  imu_req_t     pending_samples [$];
  imu_reading_t expected_readings [$];

  logic [31:0]  clock_ms   = '0;
  logic         steady     = 1'b0;
  int           fail_count = 0;
  int           cycle_count = 0;

  // Driver state
  imu_req_t     smp_cur  = '0;
  logic         smp_busy = 1'b0;
  int           smp_gap  = 0;

  // Receiver state
  int           res_stall = 0;
  imu_reading_t want_r;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Integer square root, rounded to nearest
  function automatic longint round_isqrt(input longint s);
    longint r;
    r = $rtoi($sqrt(s));
    while (r * r > s) r--;
    while ((r + 1) * (r + 1) <= s) r++;
    if (s - r * r > r) r++;
    return r;
  endfunction

  // Vectoring CORDIC: atan2(num, den) for den >= 0, in degrees Q8.8
  function automatic logic signed [15:0] cordic_deg(input longint num, input longint den);
    longint vx, vy, acc, dx, dy, q;
    int     k;
    if (num == 0 && den == 0) return '0;
    vx  = den * 256;
    vy  = num * 256;
    acc = 0;
    for (k = 0; k < CordicIters; k++) begin
      dx = vx >>> k;
      dy = vy >>> k;
      if (vy >= 0) begin
        vx  = vx + dy;
        vy  = vy - dx;
        acc = acc + atan_deg16[k];
      end else begin
        vx  = vx - dy;
        vy  = vy + dx;
        acc = acc - atan_deg16[k];
      end
    end
    // round to Q8.8 with a floor shift, then clamp to +-90 degrees
    q = (acc + 128) >>> 8;
    if (q > 23040) q = 23040;
    if (q < -23040) q = -23040;
    return q[15:0];
  endfunction

  // Advance the shadow detector by one accepted request and queue its reading
  task automatic predict_reading(input imu_req_t s);
    imu_reading_t       e;
    longint             ax, ay, az, sx, sy, sz, mag, ap, ar;
    logic signed [15:0] pitch, roll;
    logic [31:0]        since;
    e = '0;
    if (s.req_type == REQ_CLEAR) begin
      fall_flag = 1'b0;
    end else begin
      ax = $signed(s.accel_x);
      ay = $signed(s.accel_y);
      az = $signed(s.accel_z);
      sx = ax * ax;
      sy = ay * ay;
      sz = az * az;
      mag   = round_isqrt(sx + sy + sz);
      pitch = cordic_deg(ax, round_isqrt(sy + sz));
      roll  = cordic_deg(ay, round_isqrt(sx + sz));
      ap = pitch;
      ar = roll;
      if (ap < 0) ap = -ap;
      if (ar < 0) ar = -ar;
      if (ar > ap) ap = ar;
      // latch first; a fresh latch then sees a zero time difference
      if (mag > thr_impact && ap > thr_tilt) begin
        fall_flag  = 1'b1;
        fall_stamp = s.now_ms;
      end
      since = s.now_ms - fall_stamp;
      if (fall_flag && since > hold_ms) fall_flag = 1'b0;
      e.total_accel = mag[15:0];
      e.pitch_deg   = pitch;
      e.roll_deg    = roll;
    end
    e.is_fall = fall_flag;
    expected_readings.push_back(e);
  endtask

  // ---------------------------------------------------------------------------
  // Handshake timing
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Driver: present queued requests, hold each until its transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_if.valid    <= 1'b0;
      smp_if.req_type <= REQ_SAMPLE;
      smp_if.accel_x  <= '0;
      smp_if.accel_y  <= '0;
      smp_if.accel_z  <= '0;
      smp_if.now_ms   <= '0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        predict_reading(smp_cur);
        smp_busy = 1'b0;
        smp_gap  = steady ? 0 : pick_gap();
      end
      if (!smp_busy) begin
        if (smp_gap > 0) begin
          smp_gap--;
        end else if (pending_samples.size() > 0) begin
          smp_cur  = pending_samples.pop_front();
          smp_busy = 1'b1;
        end
      end
      smp_if.valid    <= smp_busy;
      smp_if.req_type <= smp_cur.req_type;
      smp_if.accel_x  <= smp_cur.accel_x;
      smp_if.accel_y  <= smp_cur.accel_y;
      smp_if.accel_z  <= smp_cur.accel_z;
      smp_if.now_ms   <= smp_cur.now_ms;
    end
  end

  // Receiver: stall ready at random, independent of valid
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_stall > 0) begin
        res_stall--;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        res_stall = pick_gap();
      end
      res_if.ready <= (res_stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      // cap the log, keep counting
      if (fail_count < 100)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: compare every result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual total_accel %0d",
                 $time, res_if.total_accel);
        fail_count++;
      end else begin
        want_r = expected_readings.pop_front();
        check_field("total_accel", 32'(want_r.total_accel), 32'(res_if.total_accel));
        check_field("pitch_deg", 32'(want_r.pitch_deg), 32'(res_if.pitch_deg));
        check_field("roll_deg", 32'(want_r.roll_deg), 32'(res_if.roll_deg));
        check_field("is_fall", 32'(want_r.is_fall), 32'(res_if.is_fall));
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("imu_fall_detector_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [31:0] t);
    imu_req_t s;
    s.req_type = REQ_SAMPLE;
    s.accel_x  = x;
    s.accel_y  = y;
    s.accel_z  = z;
    s.now_ms   = t;
    pending_samples.push_back(s);
  endtask

  // Clear request: randomize the unused fields so they prove ignored
  task automatic push_clear();
    imu_req_t s;
    s.req_type = REQ_CLEAR;
    s.accel_x  = 16'($urandom);
    s.accel_y  = 16'($urandom);
    s.accel_z  = 16'($urandom);
    s.now_ms   = $urandom;
    pending_samples.push_back(s);
  endtask

  // Random motion: mostly a steady timeline of resting and impact samples,
  // the rest clears and raw noise
  task automatic push_motion(input int n);
    int k, j, pick, axis;
    int v [3];
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_clear();
      end else if (pick < 14) begin
        push_sample(16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end else begin
        // advance the timeline, now and then jump it or run it up to the wrap
        if ($urandom_range(0, 99) == 0)
          clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
        else if ($urandom_range(0, 19) == 0)
          clock_ms = clock_ms + $urandom_range(0, 70000);
        else
          clock_ms = clock_ms + $urandom_range(0, 25);
        axis = $urandom_range(0, 2);
        if (pick < 34) begin
          // impact: one strong axis, large tilt
          for (j = 0; j < 3; j++) v[j] = $urandom_range(0, 24000) - 12000;
          v[axis] = $urandom_range(8192, 32767);
        end else begin
          // resting posture: about 1 g on one axis plus sensor noise
          for (j = 0; j < 3; j++) v[j] = $urandom_range(0, 1600) - 800;
          v[axis] = 4096 + $urandom_range(0, 1200) - 600;
        end
        if ($urandom_range(0, 1) == 1) v[axis] = -v[axis];
        push_sample(16'(v[0]), 16'(v[1]), 16'(v[2]), clock_ms);
      end
    end
  endtask

  // Hold the sender until every queued request has been answered
  task automatic drain();
    while (pending_samples.size() != 0 || smp_busy || expected_readings.size() != 0)
      @(negedge clk_i);
  endtask

  // Write all three thresholds back to back while the block is idle
  task automatic set_thresholds(input logic [15:0] impact, input logic [14:0] tilt,
                                input logic [15:0] hold);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgImpact;
    cfg_wdata_i <= impact;
    thr_impact   = impact;
    @(posedge clk_i);
    cfg_idx_i   <= CfgTilt;
    cfg_wdata_i <= {1'b0, tilt};
    thr_tilt     = tilt;
    @(posedge clk_i);
    cfg_idx_i   <= CfgHold;
    cfg_wdata_i <= hold;
    hold_ms      = hold;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    // drive the reset and configuration inputs to a known value from time zero
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed checks at the reset thresholds
    push_clear();
    push_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);            // both angle operands zero
    push_sample(16'sd0, 16'sd0, 16'sd4096, 32'd1);         // flat at rest
    push_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd2); // largest magnitude
    push_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'd3);
    push_sample(-16'sd32768, 16'sd0, 16'sd0, 32'd10);      // pitch clamps at -90, latch
    push_sample(16'sd0, 16'sd0, 16'sd4096, 32'd5000);      // still latched
    push_sample(16'sd0, 16'sd0, 16'sd4096, 32'd10010);     // exactly hold time: stays
    push_sample(16'sd0, 16'sd0, 16'sd4096, 32'd10011);     // one past: expires
    push_sample(16'sd0, 16'sd32767, 16'sd0, 32'd20000);    // roll at +90, latch
    push_clear();                                          // drop the latch
    push_sample(16'sd0, 16'sd0, -16'sd4096, 32'd20001);
    push_sample(16'sd0, -16'sd32768, 16'sd0, 32'hFFFF_FFF0); // latch just before wrap
    push_sample(16'sd0, 16'sd0, 16'sd4096, 32'd5);         // wrapped difference is small
    push_sample(16'sd12345, -16'sd23456, 16'sd5, 32'd6);
    push_clear();
    push_sample(16'sd10240, 16'sd0, 16'sd0, 32'd7);        // magnitude equal to threshold
    push_sample(16'sd10241, 16'sd0, 16'sd0, 32'd8);        // one above: latch
    clock_ms = 32'd8;
    push_motion(200);
    drain();

    // Zero thresholds and zero hold: latch and expiry in the same step
    set_thresholds(16'd0, 15'd0, 16'd0);
    push_sample(-16'sd20000, 16'sd0, 16'sd0, 32'd100);     // latch, difference zero
    push_sample(16'sd0, 16'sd0, 16'sd4096, 32'd100);       // zero tilt, same time: stays
    push_sample(16'sd0, 16'sd0, 16'sd0, 32'd100);          // zero magnitude
    push_sample(16'sd0, 16'sd0, 16'sd4096, 32'd101);       // expires
    clock_ms = 32'd101;
    push_motion(200);
    drain();

    // Highest thresholds: no fall can latch; run without any idling
    steady = 1'b1;
    set_thresholds(16'hFFFF, 15'd23040, 16'hFFFF);
    push_motion(150);
    drain();
    steady = 1'b0;

    // Default thresholds, short hold so latches expire often
    set_thresholds(16'd10240, 15'd15360, 16'd200);
    push_motion(150);
    // hold the sender until the block has answered everything
    drain();
    push_motion(150);
    drain();

    // Random thresholds
    set_thresholds(16'($urandom_range(2048, 24576)), 15'($urandom_range(0, 23040)),
                   16'($urandom_range(0, 500)));
    push_motion(300);
    drain();

    set_thresholds(16'(4096 + $urandom_range(0, 4096)), 15'd7680, 16'd60);
    push_motion(380);
    drain();

    // let any stray result show up
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("imu_fall_detector_unit test passed");
    end else begin
      $display("imu_fall_detector_unit test failed");
    end
    $finish;
  end

endmodule
